FILE: rtl/core/scp_pkg.sv
// Shared constants for the segment contact point unit.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package scp_pkg;

  // Default geometry: coordinates with 4 fractional bits, t with 16
  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // Division lanes: four endpoint projections and the crossing parameter
  localparam int unsigned NUM_LANES = 5;
  localparam int unsigned LANE_A    = 0;  // a projected onto cd
  localparam int unsigned LANE_B    = 1;  // b projected onto cd
  localparam int unsigned LANE_C    = 2;  // c projected onto ab
  localparam int unsigned LANE_D    = 3;  // d projected onto ab
  localparam int unsigned LANE_X    = 4;  // crossing parameter along ab

endpackage

`default_nettype wire

FILE: rtl/core/scp_front.sv
// Front end: differences, determinant and dot products, sign fix-up and
// clamped dividend/divisor set-up for the divider lanes. Uses scp_pkg.
`default_nettype none

module scp_front import scp_pkg::*; #(
  parameter int unsigned C     = COORD_WIDTH_DEF,
  parameter int unsigned F     = FRAC_BITS_DEF,
  parameter int unsigned DEN_W = 2 * C + 2,
  parameter int unsigned NW    = DEN_W + F + 1,
  parameter int unsigned TAG_W = 8 * C + 4 * (C + 1) + 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic signed [C-1:0] ax_i,
  input  wire logic signed [C-1:0] ay_i,
  input  wire logic signed [C-1:0] bx_i,
  input  wire logic signed [C-1:0] by_i,
  input  wire logic signed [C-1:0] cx_i,
  input  wire logic signed [C-1:0] cy_i,
  input  wire logic signed [C-1:0] dx_i,
  input  wire logic signed [C-1:0] dy_i,
  output logic                     valid_o,
  output logic [NW-1:0]            n_o   [NUM_LANES],
  output logic [DEN_W-1:0]         den_o [NUM_LANES],
  output logic [TAG_W-1:0]         tag_o
);

  localparam int unsigned DW = C + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned PT_W = TAG_W - 1;

  // a*b +/- c*d, exact
  function automatic logic signed [SW-1:0] mac2(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b,
                                                input logic signed [DW-1:0] c,
                                                input logic signed [DW-1:0] d,
                                                input logic sub);
    logic signed [PW-1:0] p0;
    logic signed [PW-1:0] p1;
    p0 = a * b;
    p1 = c * d;
    return sub ? (SW'(p0) - SW'(p1)) : (SW'(p0) + SW'(p1));
  endfunction

  // num clamped to [0, den]
  function automatic logic [DEN_W-1:0] clamp(input logic signed [SW-1:0] num,
                                             input logic signed [SW-1:0] den);
    logic [DEN_W-1:0] r;
    if (num <= 0) r = '0;
    else if (num >= den) r = den[DEN_W-1:0];
    else r = num[DEN_W-1:0];
    return r;
  endfunction

  logic [3:0] vld_q;

  // stage 1: differences
  logic signed [DW-1:0] abx_q, aby_q, cdx_q, cdy_q, acx_q, acy_q;
  logic signed [DW-1:0] cax_q, cay_q, bcx_q, bcy_q, adx_q, ady_q;
  logic signed [DW-1:0] abx_d, aby_d, cdx_d, cdy_d;
  logic [PT_W-1:0] tag1_q, tag2_q, tag3_q;

  // stage 2: products
  logic signed [SW-1:0] det2_q, tn2_q, un2_q, l2ab_q, l2cd_q;
  logic signed [SW-1:0] pn2_q [4];

  // stage 3: sign-normalised determinant
  logic signed [SW-1:0] det3_q, tn3_q, un3_q, l2ab3_q, l2cd3_q;
  logic signed [SW-1:0] pn3_q [4];
  logic                 detnz3_q;

  // stage 4: divider set-up
  logic [NW-1:0]    n_q   [NUM_LANES];
  logic [DEN_W-1:0] den_q [NUM_LANES];
  logic             cross_q;
  logic [PT_W-1:0]  tag4_q;

  logic [NW-1:0]    n_d   [NUM_LANES];
  logic [DEN_W-1:0] den_d [NUM_LANES];
  logic [DEN_W-1:0] num_d [NUM_LANES];
  logic             cross_d;

  assign abx_d = DW'(bx_i) - DW'(ax_i);
  assign aby_d = DW'(by_i) - DW'(ay_i);
  assign cdx_d = DW'(dx_i) - DW'(cx_i);
  assign cdy_d = DW'(dy_i) - DW'(cy_i);

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      abx_q  <= abx_d;
      aby_q  <= aby_d;
      cdx_q  <= cdx_d;
      cdy_q  <= cdy_d;
      acx_q  <= DW'(cx_i) - DW'(ax_i);
      acy_q  <= DW'(cy_i) - DW'(ay_i);
      cax_q  <= DW'(ax_i) - DW'(cx_i);
      cay_q  <= DW'(ay_i) - DW'(cy_i);
      bcx_q  <= DW'(bx_i) - DW'(cx_i);
      bcy_q  <= DW'(by_i) - DW'(cy_i);
      adx_q  <= DW'(dx_i) - DW'(ax_i);
      ady_q  <= DW'(dy_i) - DW'(ay_i);
      tag1_q <= {cdy_d, cdx_d, aby_d, abx_d, dy_i, dx_i, cy_i, cx_i, by_i, bx_i, ay_i, ax_i};
    end
  end

  // stage 2: determinant, crossing numerators, projection dot products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det2_q   <= mac2(abx_q, cdy_q, aby_q, cdx_q, 1'b1);
      tn2_q    <= mac2(acx_q, cdy_q, acy_q, cdx_q, 1'b1);
      un2_q    <= mac2(acx_q, aby_q, acy_q, abx_q, 1'b1);
      pn2_q[0] <= mac2(cax_q, cdx_q, cay_q, cdy_q, 1'b0);
      pn2_q[1] <= mac2(bcx_q, cdx_q, bcy_q, cdy_q, 1'b0);
      pn2_q[2] <= mac2(acx_q, abx_q, acy_q, aby_q, 1'b0);
      pn2_q[3] <= mac2(adx_q, abx_q, ady_q, aby_q, 1'b0);
      l2cd_q   <= mac2(cdx_q, cdx_q, cdy_q, cdy_q, 1'b0);
      l2ab_q   <= mac2(abx_q, abx_q, aby_q, aby_q, 1'b0);
      tag2_q   <= tag1_q;
    end
  end

  // stage 3: make the determinant positive
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det3_q   <= (det2_q < 0) ? -det2_q : det2_q;
      tn3_q    <= (det2_q < 0) ? -tn2_q : tn2_q;
      un3_q    <= (det2_q < 0) ? -un2_q : un2_q;
      detnz3_q <= (det2_q != 0);
      pn3_q    <= pn2_q;
      l2ab3_q  <= l2ab_q;
      l2cd3_q  <= l2cd_q;
      tag3_q   <= tag2_q;
    end
  end

  // stage 4: crossing test, clamp, dividend with half-divisor rounding term
  always_comb begin
    cross_d = detnz3_q && (tn3_q >= 0) && (tn3_q <= det3_q) &&
              (un3_q >= 0) && (un3_q <= det3_q);
    for (int k = 0; k < 4; k++) begin
      if (((k < 2) ? l2cd3_q : l2ab3_q) == 0) begin
        den_d[k] = DEN_W'(1);
        num_d[k] = '0;
      end else begin
        den_d[k] = (k < 2) ? l2cd3_q[DEN_W-1:0] : l2ab3_q[DEN_W-1:0];
        num_d[k] = clamp(pn3_q[k], (k < 2) ? l2cd3_q : l2ab3_q);
      end
    end
    if (!detnz3_q) begin
      den_d[LANE_X] = DEN_W'(1);
      num_d[LANE_X] = '0;
    end else begin
      den_d[LANE_X] = det3_q[DEN_W-1:0];
      num_d[LANE_X] = clamp(tn3_q, det3_q);
    end
    for (int l = 0; l < NUM_LANES; l++) begin
      n_d[l] = {1'b0, num_d[l], {F{1'b0}}} + NW'(den_d[l] >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q     <= n_d;
      den_q   <= den_d;
      cross_q <= cross_d;
      tag4_q  <= tag3_q;
    end
  end

  assign valid_o = vld_q[3];
  assign n_o     = n_q;
  assign den_o   = den_q;
  assign tag_o   = {cross_q, tag4_q};

endmodule

`default_nettype wire

FILE: rtl/core/scp_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one valid and one side-band tag. Uses scp_pkg.
`default_nettype none

module scp_div import scp_pkg::*; #(
  parameter int unsigned F     = FRAC_BITS_DEF,
  parameter int unsigned DEN_W = 2 * COORD_WIDTH_DEF + 2,
  parameter int unsigned NW    = DEN_W + F + 1,
  parameter int unsigned TAG_W = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [NW-1:0]    n_i   [NUM_LANES],
  input  wire logic [DEN_W-1:0] den_i [NUM_LANES],
  input  wire logic [TAG_W-1:0] tag_i,
  output logic                  valid_o,
  output logic [F:0]            quo_o [NUM_LANES],
  output logic [TAG_W-1:0]      tag_o
);

  localparam int unsigned STEPS = F + 1;
  localparam int unsigned TW    = F + 1;
  localparam logic [TW-1:0] ONE_T = TW'(1) << F;

  logic [STEPS-1:0] vld_q;

  logic [DEN_W-1:0] rem_q [STEPS][NUM_LANES];
  logic [DEN_W-1:0] den_q [STEPS][NUM_LANES];
  logic [F:0]       nlo_q [STEPS][NUM_LANES];
  logic [TW-1:0]    quo_q [STEPS][NUM_LANES];
  logic [TAG_W-1:0] tag_q [STEPS];

  logic [DEN_W-1:0] rem_s [STEPS][NUM_LANES];
  logic [DEN_W-1:0] den_s [STEPS][NUM_LANES];
  logic [F:0]       nlo_s [STEPS][NUM_LANES];
  logic [TW-1:0]    quo_s [STEPS][NUM_LANES];
  logic [TAG_W-1:0] tag_s [STEPS];

  logic [DEN_W:0]   rs    [STEPS][NUM_LANES];
  logic             ge    [STEPS][NUM_LANES];
  logic [DEN_W-1:0] rem_d [STEPS][NUM_LANES];
  logic [TW-1:0]    quo_d [STEPS][NUM_LANES];

  // stage sources: the first stage takes the ports, others the stage before
  always_comb begin
    tag_s[0] = tag_i;
    for (int l = 0; l < NUM_LANES; l++) begin
      rem_s[0][l] = n_i[l][NW-1:F+1];
      nlo_s[0][l] = n_i[l][F:0];
      den_s[0][l] = den_i[l];
      quo_s[0][l] = '0;
    end
    for (int s = 1; s < STEPS; s++) begin
      tag_s[s] = tag_q[s-1];
      for (int l = 0; l < NUM_LANES; l++) begin
        rem_s[s][l] = rem_q[s-1][l];
        nlo_s[s][l] = nlo_q[s-1][l];
        den_s[s][l] = den_q[s-1][l];
        quo_s[s][l] = quo_q[s-1][l];
      end
    end
  end

  // one shift, compare and subtract per stage
  always_comb begin
    for (int s = 0; s < STEPS; s++) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        rs[s][l]    = {rem_s[s][l], nlo_s[s][l][F-s]};
        ge[s][l]    = (rs[s][l] >= {1'b0, den_s[s][l]});
        rem_d[s][l] = ge[s][l] ? DEN_W'(rs[s][l] - {1'b0, den_s[s][l]})
                               : rs[s][l][DEN_W-1:0];
        quo_d[s][l] = {quo_s[s][l][TW-2:0], ge[s][l]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STEPS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_s;
      nlo_q <= nlo_s;
      quo_q <= quo_d;
      tag_q <= tag_s;
    end
  end

  assign valid_o = vld_q[STEPS-1];
  assign tag_o   = tag_q[STEPS-1];
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      quo_o[l] = quo_q[STEPS-1][l];
    end
  end

  // dividend set-up keeps every quotient within [0, 1]
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_chk
    a_in_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (valid_i && en_i) |-> (n_i[l][NW-1:F+1] < den_i[l]))
      else $error("divider lane entered with top dividend bits not below divisor");
    a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid_o |-> (rem_q[STEPS-1][l] < den_q[STEPS-1][l]))
      else $error("divider remainder not below divisor");
    a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid_o |-> (quo_o[l] <= ONE_T))
      else $error("segment parameter above one");
  end

endmodule

`default_nettype wire

FILE: rtl/core/scp_back.sv
// Back end: points along the segments, squared distances, nearest pair,
// midpoint and saturation into the output register. Uses scp_pkg.
`default_nettype none

module scp_back import scp_pkg::*; #(
  parameter int unsigned C     = COORD_WIDTH_DEF,
  parameter int unsigned F     = FRAC_BITS_DEF,
  parameter int unsigned TAG_W = 8 * C + 4 * (C + 1) + 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic [F:0]          quo_i [NUM_LANES],
  input  wire logic [TAG_W-1:0]    tag_i,
  output logic                     valid_o,
  output logic signed [C-1:0]      contact_x_o,
  output logic signed [C-1:0]      contact_y_o,
  output logic                     crossing_o
);

  localparam int unsigned DW     = C + 1;
  localparam int unsigned TW     = F + 1;
  localparam int unsigned PRW    = DW + TW + 1;
  localparam int unsigned QW     = C + 2;
  localparam int unsigned DXW    = QW + 1;
  localparam int unsigned DIST_W = 2 * C + 1;
  localparam int unsigned SMW    = QW + 1;
  localparam logic signed [PRW-1:0] HALF = PRW'(1) << (F - 1);
  localparam logic signed [SMW-1:0] CMAX = {{(SMW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [SMW-1:0] CMIN = ~CMAX;

  logic [4:0] vld_q;

  // unpacked side band
  logic signed [C-1:0]  px_t [4];
  logic signed [C-1:0]  py_t [4];
  logic signed [DW-1:0] abx_t, aby_t, cdx_t, cdy_t;
  logic                 cross_t;

  // stage b1: products
  logic signed [PRW-1:0] prx_d [NUM_LANES];
  logic signed [PRW-1:0] pry_d [NUM_LANES];
  logic signed [PRW-1:0] prx_q [NUM_LANES];
  logic signed [PRW-1:0] pry_q [NUM_LANES];
  logic signed [C-1:0]   px1_q [4];
  logic signed [C-1:0]   py1_q [4];
  logic                  cross1_q;

  // stage b2: points on the segments
  logic signed [PRW-1:0] rndx [NUM_LANES];
  logic signed [PRW-1:0] rndy [NUM_LANES];
  logic signed [QW-1:0]  qx_q [NUM_LANES];
  logic signed [QW-1:0]  qy_q [NUM_LANES];
  logic signed [C-1:0]   px2_q [4];
  logic signed [C-1:0]   py2_q [4];
  logic                  cross2_q;

  // stage b3: squared distances
  logic signed [DXW-1:0]   ddx [4];
  logic signed [DXW-1:0]   ddy [4];
  logic signed [2*DXW-1:0] sqx [4];
  logic signed [2*DXW-1:0] sqy [4];
  logic [DIST_W-1:0]       dist_q [4];
  logic signed [QW-1:0]    qx3_q [NUM_LANES];
  logic signed [QW-1:0]    qy3_q [NUM_LANES];
  logic signed [C-1:0]     px3_q [4];
  logic signed [C-1:0]     py3_q [4];
  logic                    cross3_q;

  // stage b4: pairwise minimum
  logic [DIST_W-1:0]    d01_q, d23_q;
  logic signed [C-1:0]  p01x_q, p01y_q, p23x_q, p23y_q;
  logic signed [QW-1:0] q01x_q, q01y_q, q23x_q, q23y_q, qxx_q, qxy_q;
  logic                 cross4_q;
  logic                 sel01, sel23;

  // stage b5: result
  logic                 sel;
  logic signed [SMW-1:0] midx, midy, resx, resy;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      px_t[k] = tag_i[(2*k)*C +: C];
      py_t[k] = tag_i[(2*k+1)*C +: C];
    end
    abx_t   = tag_i[8*C +: DW];
    aby_t   = tag_i[8*C + DW +: DW];
    cdx_t   = tag_i[8*C + 2*DW +: DW];
    cdy_t   = tag_i[8*C + 3*DW +: DW];
    cross_t = tag_i[TAG_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // b1: direction times t
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (l == LANE_A || l == LANE_B) begin
        prx_d[l] = cdx_t * $signed({1'b0, quo_i[l]});
        pry_d[l] = cdy_t * $signed({1'b0, quo_i[l]});
      end else begin
        prx_d[l] = abx_t * $signed({1'b0, quo_i[l]});
        pry_d[l] = aby_t * $signed({1'b0, quo_i[l]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prx_q    <= prx_d;
      pry_q    <= pry_d;
      px1_q    <= px_t;
      py1_q    <= py_t;
      cross1_q <= cross_t;
    end
  end

  // b2: round the product back and add the segment start
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      rndx[l] = prx_q[l] + HALF;
      rndy[l] = pry_q[l] + HALF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        if (l == LANE_A || l == LANE_B) begin
          qx_q[l] <= QW'(px1_q[LANE_C]) + QW'(rndx[l] >>> F);
          qy_q[l] <= QW'(py1_q[LANE_C]) + QW'(rndy[l] >>> F);
        end else begin
          qx_q[l] <= QW'(px1_q[LANE_A]) + QW'(rndx[l] >>> F);
          qy_q[l] <= QW'(py1_q[LANE_A]) + QW'(rndy[l] >>> F);
        end
      end
      px2_q    <= px1_q;
      py2_q    <= py1_q;
      cross2_q <= cross1_q;
    end
  end

  // b3: squared distance from each endpoint to its projection
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ddx[k] = DXW'(px2_q[k]) - DXW'(qx_q[k]);
      ddy[k] = DXW'(py2_q[k]) - DXW'(qy_q[k]);
      sqx[k] = ddx[k] * ddx[k];
      sqy[k] = ddy[k] * ddy[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        dist_q[k] <= DIST_W'(sqx[k] + sqy[k]);
      end
      qx3_q    <= qx_q;
      qy3_q    <= qy_q;
      px3_q    <= px2_q;
      py3_q    <= py2_q;
      cross3_q <= cross2_q;
    end
  end

  // b4: earlier endpoint wins a tie
  assign sel01 = dist_q[1] < dist_q[0];
  assign sel23 = dist_q[3] < dist_q[2];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d01_q    <= sel01 ? dist_q[1] : dist_q[0];
      p01x_q   <= sel01 ? px3_q[1] : px3_q[0];
      p01y_q   <= sel01 ? py3_q[1] : py3_q[0];
      q01x_q   <= sel01 ? qx3_q[1] : qx3_q[0];
      q01y_q   <= sel01 ? qy3_q[1] : qy3_q[0];
      d23_q    <= sel23 ? dist_q[3] : dist_q[2];
      p23x_q   <= sel23 ? px3_q[3] : px3_q[2];
      p23y_q   <= sel23 ? py3_q[3] : py3_q[2];
      q23x_q   <= sel23 ? qx3_q[3] : qx3_q[2];
      q23y_q   <= sel23 ? qy3_q[3] : qy3_q[2];
      qxx_q    <= qx3_q[LANE_X];
      qxy_q    <= qy3_q[LANE_X];
      cross4_q <= cross3_q;
    end
  end

  // b5: midpoint rounded half up, or the crossing point; saturate
  always_comb begin
    sel  = d23_q < d01_q;
    midx = (SMW'(sel ? p23x_q : p01x_q) + SMW'(sel ? q23x_q : q01x_q) + SMW'(1)) >>> 1;
    midy = (SMW'(sel ? p23y_q : p01y_q) + SMW'(sel ? q23y_q : q01y_q) + SMW'(1)) >>> 1;
    resx = cross4_q ? SMW'(qxx_q) : midx;
    resy = cross4_q ? SMW'(qxy_q) : midy;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      contact_x_o <= (resx > CMAX) ? CMAX[C-1:0] : (resx < CMIN) ? CMIN[C-1:0] : resx[C-1:0];
      contact_y_o <= (resy > CMAX) ? CMAX[C-1:0] : (resy < CMIN) ? CMIN[C-1:0] : resy[C-1:0];
      crossing_o  <= cross4_q;
    end
  end

  assign valid_o = vld_q[4];

endmodule

`default_nettype wire

FILE: rtl/core/segment_contact_point_unit.sv
// Segment contact point unit: top level tying front end, divider and back end.
// Depends on scp_pkg, scp_front, scp_div and scp_back.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item: two segments
//   a->b (seg1_*) and c->d (seg2_*), signed fixed point, 4 fractional bits.
//   Output channel (out_valid_o / out_ready_i) returns one item per input:
//   contact point and a crossing flag (1 = true intersection, 0 = midpoint
//   of the nearest endpoint and its clamped projection).
//   The pipe has four set-up stages, one divider stage per quotient bit of t
//   and five back-end stages. Throughput is one item per cycle while the
//   output is not stalled; five divider lanes run side by side.
//   Every stage advances together while the output register is empty or
//   being taken. When the receiver stalls a full output, the whole pipe
//   holds and in_ready_o drops; nothing is lost or repeated.
//   Reset clears all valid bits; no state survives between items.
`default_nettype none

module segment_contact_point_unit import scp_pkg::*; #(
  parameter int unsigned COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int unsigned PARAM_FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0] seg1_x0_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg1_y0_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg1_x1_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg1_y1_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg2_x0_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg2_y0_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg2_x1_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg2_y1_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0]      contact_x_o,
  output logic signed [COORD_WIDTH-1:0]      contact_y_o,
  output logic                               crossing_o
);

  localparam int unsigned C     = COORD_WIDTH;
  localparam int unsigned F     = PARAM_FRAC_BITS;
  localparam int unsigned DEN_W = 2 * C + 2;
  localparam int unsigned NW    = DEN_W + F + 1;
  localparam int unsigned TAG_W = 8 * C + 4 * (C + 1) + 1;

  logic             en;
  logic             fe_valid, dv_valid;
  logic [NW-1:0]    fe_n   [NUM_LANES];
  logic [DEN_W-1:0] fe_den [NUM_LANES];
  logic [TAG_W-1:0] fe_tag, dv_tag;
  logic [F:0]       dv_quo [NUM_LANES];

  // pipe moves whenever the output register is free or being emptied
  assign en         = out_ready_i || !out_valid_o;
  assign in_ready_o = en;

  scp_front #(.C(C), .F(F), .DEN_W(DEN_W), .NW(NW), .TAG_W(TAG_W)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .ax_i    (seg1_x0_i),
    .ay_i    (seg1_y0_i),
    .bx_i    (seg1_x1_i),
    .by_i    (seg1_y1_i),
    .cx_i    (seg2_x0_i),
    .cy_i    (seg2_y0_i),
    .dx_i    (seg2_x1_i),
    .dy_i    (seg2_y1_i),
    .valid_o (fe_valid),
    .n_o     (fe_n),
    .den_o   (fe_den),
    .tag_o   (fe_tag)
  );

  scp_div #(.F(F), .DEN_W(DEN_W), .NW(NW), .TAG_W(TAG_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fe_valid),
    .n_i     (fe_n),
    .den_i   (fe_den),
    .tag_i   (fe_tag),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .tag_o   (dv_tag)
  );

  scp_back #(.C(C), .F(F), .TAG_W(TAG_W)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (dv_valid),
    .quo_i       (dv_quo),
    .tag_i       (dv_tag),
    .valid_o     (out_valid_o),
    .contact_x_o (contact_x_o),
    .contact_y_o (contact_y_o),
    .crossing_o  (crossing_o)
  );

endmodule

`default_nettype wire
